// File: rtl/mmhc_pkg.sv
// mmhc_pkg: shared types and constants for the min/max heat-map colorizer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mmhc_pkg;

  // quotient bits of floor(K*t/d); the largest quotient is 512
  localparam int QBITS = 10;
  localparam int CNT_W = 4;

  localparam logic [7:0] PIX_FULL = 8'd255;
  localparam logic [7:0] PIX_ZERO = 8'd0;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic REQ_GATHER = 1'b0;
  localparam logic REQ_MAP    = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic gather;    // fold accepted sample into range
    logic first;     // gather restarts the range
    logic load;      // capture map sample
    logic calc1;     // range checks, d and t
    logic calc2;     // numerator, half and zero tests
    logic div_step;  // one restoring division step
    logic finish;    // build pixel into output register
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/mmhc_ctrl.sv
// mmhc_ctrl: sequencing FSM for the heat-map colorizer.
// Depends on mmhc_pkg (cmd_t, QBITS, CNT_W, REQ_* codes).
`default_nettype none

module mmhc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic         in_req_type,
  input  wire logic         in_first,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output mmhc_pkg::cmd_t    cmd
);
  import mmhc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_GATHER) begin
            cmd.gather = 1'b1;
            cmd.first  = in_first;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_CALC1;
          end
        end
      end
      S_CALC1: begin
        cmd.calc1 = 1'b1;
        state_nxt = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2 = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QBITS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mmhc_dpath.sv
// mmhc_dpath: range registers, restoring divider and pixel builder.
// Depends on mmhc_pkg (cmd_t, QBITS, pixel and channel constants).
`default_nettype none

module mmhc_dpath #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mmhc_pkg::cmd_t                cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_data,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic [7:0]                         alpha,
  output logic                               out_of_range
);
  import mmhc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int W  = SB + QBITS;

  logic signed [SB-1:0] lo_r, hi_r, smp_r;
  logic [1:0]           chan_r;
  logic [SB-1:0]        d_r, t_r;
  logic                 oor_r, half_r, dz_r;
  logic [W-1:0]         rem_r, dsh_r;
  logic [QBITS-1:0]     q_r;
  logic [7:0]           red_r, green_r, blue_r, alpha_r;
  logic                 oor_out_r;

  logic signed [SB:0]   d_wide, t_wide;
  logic [W-1:0]         num512, num2, num;
  logic                 half;
  logic [W-1:0]         rem_sub;
  logic                 ge;
  logic [7:0]           col, oth, alp;

  // control state: range and channel select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= '0;
      chan_r <= CH_RED;
    end else begin
      if (cfg_we) begin
        chan_r <= cfg_data;
      end
      if (cmd.gather) begin
        if (cmd.first) begin
          lo_r <= sample;
          hi_r <= sample;
        end else begin
          if (sample < lo_r) begin
            lo_r <= sample;
          end
          if (sample > hi_r) begin
            hi_r <= sample;
          end
        end
      end
    end
  end

  assign d_wide = {hi_r[SB-1], hi_r} - {lo_r[SB-1], lo_r};
  assign t_wide = {smp_r[SB-1], smp_r} - {lo_r[SB-1], lo_r};

  // numerator: 510t = 512t - 2t, or 512t past the midpoint
  assign num512 = {{(QBITS-9){1'b0}}, t_r, 9'b0};
  assign num2   = {{(QBITS-1){1'b0}}, t_r, 1'b0};
  assign half   = ({t_r, 1'b0} <= {1'b0, d_r});
  assign num    = half ? (num512 - num2) : num512;

  assign ge      = (rem_r >= dsh_r);
  assign rem_sub = rem_r - dsh_r;

  // pixel build from quotient
  always_comb begin
    col = PIX_FULL;
    oth = PIX_ZERO;
    alp = PIX_FULL;
    if (oor_r) begin
      col = PIX_ZERO;
      alp = PIX_ZERO;
    end else if (dz_r) begin
      col = PIX_FULL;
    end else if (half_r) begin
      col = q_r[7:0];
    end else begin
      oth = q_r[QBITS-1] ? PIX_FULL : q_r[7:0];  // q - 256, clipped
    end
    if (chan_r != CH_RED && chan_r != CH_GREEN && chan_r != CH_BLUE) begin
      col = PIX_ZERO;
      oth = PIX_ZERO;
      alp = PIX_ZERO;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= sample;
    end
    if (cmd.calc1) begin
      oor_r <= (smp_r < lo_r) || (smp_r > hi_r);
      d_r   <= d_wide[SB-1:0];
      t_r   <= t_wide[SB-1:0];
    end
    if (cmd.calc2) begin
      half_r <= half;
      dz_r   <= (d_r == '0);
      rem_r  <= num;
      dsh_r  <= {1'b0, d_r, {(QBITS-1){1'b0}}};
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      q_r   <= {q_r[QBITS-2:0], ge};
      dsh_r <= {1'b0, dsh_r[W-1:1]};
    end
    if (cmd.finish) begin
      red_r     <= (chan_r == CH_RED)   ? col : oth;
      green_r   <= (chan_r == CH_GREEN) ? col : oth;
      blue_r    <= (chan_r == CH_BLUE)  ? col : oth;
      alpha_r   <= alp;
      oor_out_r <= oor_r;
    end
  end

  assign red          = red_r;
  assign green        = green_r;
  assign blue         = blue_r;
  assign alpha        = alpha_r;
  assign out_of_range = oor_out_r;

endmodule

`default_nettype wire

// File: rtl/minmax_heatmap_colorizer.sv
// minmax_heatmap_colorizer: top level of the two-pass min/max heat-map colorizer.
// Depends on mmhc_pkg, mmhc_ctrl and mmhc_dpath.
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_tvalid/in_tready    tdata: sample; tuser: req_type, first
// out      out  out_tvalid/out_tready  tdata: red, green, blue, alpha; tuser: out_of_range
// cfg      in   cfg_valid/cfg_ready    cfg_data: channel_select
//
// A gather transaction updates the range in its accept cycle and is done;
// in_tready stays high, so gathers run one per cycle while no map item is in progress.
// A map transaction runs the setup states CALC1 and CALC2, ten restoring-division
// steps (one quotient bit each) and one output load before the next accept.
// The output register holds a result until taken; the next map item is
// accepted meanwhile and stalls only at its output load.
// Reset (rst_n low, synchronous) clears range to 0..0 and channel_select to red.
// cfg_ready is always high; write only while the block is idle.

module minmax_heatmap_colorizer #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [SAMPLE_BITS-1:0] sample, zero padding above
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  // [0] req_type, [1] first
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic [31:0]                            out_tdata,
  // [0] out_of_range
  output logic [0:0]                             out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_data
);
  import mmhc_pkg::*;

  cmd_t                        cmd;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [7:0]                  red, green, blue, alpha;
  logic                        oor;

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign cfg_ready = 1'b1;

  mmhc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser[0]),
    .in_first    (in_tuser[1]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd)
  );

  mmhc_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sample       (sample),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .out_of_range (oor)
  );

  assign out_tdata = {alpha, blue, green, red};
  assign out_tuser = oor;

endmodule

`default_nettype wire

// File: tb/sv/colorizer_check.sv
// colorizer_check: watches the in, out and cfg channels of the heat-map colorizer,
// predicts each mapped pixel and compares it with the result transaction.
// Depends on mmhc_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps
`default_nettype none

module colorizer_check #(
  parameter int SAMPLE_BITS = 32,
  parameter int DW          = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tready,
  input  wire logic [DW-1:0] in_tdata,
  input  wire logic [1:0]    in_tuser,
  input  wire logic          out_tvalid,
  input  wire logic          out_tready,
  input  wire logic [31:0]   out_tdata,
  input  wire logic [0:0]    out_tuser,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic [1:0]    cfg_data,
  output int unsigned        fail_cnt,
  output int                 open_cnt
);
  import mmhc_pkg::*;

  typedef struct packed {
    logic       oor;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic [1:0]                    ch_sel;
  logic signed [SAMPLE_BITS-1:0] rng_lo;
  logic signed [SAMPLE_BITS-1:0] rng_hi;
  pixel_t                        pixels_due[$];

  // gradient of the sample against the gathered range, on the selected channel
  function automatic pixel_t paint(logic signed [SAMPLE_BITS-1:0] smp);
    pixel_t     px;
    logic [63:0] span, ofs, q;
    logic [7:0] grad, rest;
    px   = '0;
    grad = PIX_ZERO;
    rest = PIX_ZERO;
    if (smp < rng_lo || smp > rng_hi) begin
      px.oor = 1'b1;
    end else begin
      span = 64'(longint'(rng_hi) - longint'(rng_lo));
      ofs  = 64'(longint'(smp) - longint'(rng_lo));
      if (span == 0) begin
        grad = PIX_FULL;
      end else if (2 * ofs <= span) begin
        grad = 8'((ofs * 510) / span);
      end else begin
        q    = (ofs * 512) / span;
        grad = PIX_FULL;
        rest = (q - 256 > 255) ? PIX_FULL : 8'(q - 256);
      end
      px.alpha = PIX_FULL;
    end
    case (ch_sel)
      CH_RED:   begin px.red = grad; px.green = rest; px.blue = rest; end
      CH_GREEN: begin px.red = rest; px.green = grad; px.blue = rest; end
      CH_BLUE:  begin px.red = rest; px.green = rest; px.blue = grad; end
      // spare channel code: blank pixel, range flag still reported
      default:  px.alpha = PIX_ZERO;
    endcase
    return px;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t                        got, want;
    logic signed [SAMPLE_BITS-1:0] smp;
    if (!rst_n) begin
      ch_sel   = CH_RED;
      rng_lo   = '0;
      rng_hi   = '0;
      fail_cnt = 0;
      pixels_due.delete();
      open_cnt <= 0;
    end else begin
      // a result never belongs to an item accepted at the same edge
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata};
        if (pixels_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result, tdata %h tuser %b", $time, out_tdata, out_tuser);
        end else begin
          want = pixels_due.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("out_of_range", 8'(want.oor), 8'(got.oor));
        end
      end
      if (cfg_valid && cfg_ready)
        ch_sel = cfg_data;
      if (in_tvalid && in_tready) begin
        smp = in_tdata[SAMPLE_BITS-1:0];
        if (in_tuser[0] == REQ_GATHER) begin
          if (in_tuser[1]) begin
            rng_lo = smp;
            rng_hi = smp;
          end else begin
            if (smp < rng_lo) rng_lo = smp;
            if (smp > rng_hi) rng_hi = smp;
          end
        end else begin
          pixels_due.push_back(paint(smp));
        end
      end
      open_cnt <= pixels_due.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench: stimulus and verdict for minmax_heatmap_colorizer.
// Depends on mmhc_pkg, the colorizer RTL and colorizer_check (prediction, compare).
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import mmhc_pkg::*;

  localparam int SB          = 32;
  localparam int DW          = ((SB + 7) / 8) * 8;
  localparam int LIMIT       = 300000;  // watchdog limit, in cycles
  localparam int DRAIN       = 40;      // extra cycles settle() waits, for an in-flight map plus output stall
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD        = 300;     // long sink hold-off, fills the block
  localparam logic [1:0] CH_SPARE = 2'd3;  // unused channel code, blanks pixels
  localparam int NPH = 7;
  // channel per phase, phase 0 in the low bits: red, green, blue, spare, blue, green, red
  localparam logic [2*NPH-1:0] PHASE_CH =
    {CH_RED, CH_GREEN, CH_BLUE, CH_SPARE, CH_BLUE, CH_GREEN, CH_RED};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] S_MAX = ~S_MIN;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;   // [SB-1:0] sample
  logic [1:0]    in_tuser;   // [0] req_type, [1] first
  logic          out_tvalid;
  logic          out_tready;
  logic [31:0]   out_tdata;  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic [0:0]    out_tuser;  // [0] out_of_range
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_data;
  int unsigned   fail_cnt;
  int            open_cnt;   // pixels still owed by the block

  // Stimulus-side view of the gathered range, used only to aim map samples
  // inside, on the edges of, or just outside the current range.
  logic signed [SB-1:0] span_lo, span_hi;
  logic [SB-1:0]        base;       // first sample of the current gather run
  int                   sent;       // transactions accepted in this phase
  bit                   src_idle_on;
  bit                   sink_idle_on;
  int                   hold_len = 0;  // set by stimulus, consumed by the sink
  int                   cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  minmax_heatmap_colorizer #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  colorizer_check #(.SAMPLE_BITS(SB)) check_u (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_cnt(fail_cnt), .open_cnt(open_cnt)
  );

  // Result sink. Exactly one nonblocking write of out_tready per edge it acts on.
  // A hold request parks tready low for a long stretch so maps back up and
  // in_tready drops; otherwise random stalls of random length when enabled.
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a missing result or a hung handshake lands here.
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // One input transaction. valid stays high after acceptance so back-to-back
  // items need no extra NBA; a gap or settle() lowers it.
  task automatic push_item(logic req, logic [SB-1:0] smp, logic first);
    logic signed [SB-1:0] v;
    v = smp;
    if (src_idle_on && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(smp);
    in_tuser  <= {first, req};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (req == REQ_GATHER) begin
      if (first) begin
        span_lo = v;
        span_hi = v;
      end else begin
        if (v < span_lo) span_lo = v;
        if (v > span_hi) span_hi = v;
      end
    end
  endtask

  // Quiesce: wait for every owed pixel, then let any in-flight map finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_cnt != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_channel(logic [1:0] ch);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= ch;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Gather values: full-width noise, small signed ints, the two extremes,
  // whole Q16.16 numbers, or a close neighbor of the run's first sample
  // (gives tiny ranges where every quotient step shows).
  function automatic logic [SB-1:0] pick_sample();
    int k;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: begin k = $urandom_range(0, 4000); return SB'(k - 2000); end
      2: return ($urandom_range(0, 1) == 0) ? S_MIN : S_MAX;
      3: begin k = $urandom_range(0, 200); return SB'((k - 100) * 65536); end
      default: begin k = $urandom_range(0, 64); return base + SB'(k - 32); end
    endcase
  endfunction

  // Map sample inside the range, biased to the ends and the half point,
  // where the gradient switches from one leg to the other.
  function automatic logic [SB-1:0] pick_in_range();
    longint d, o;
    d = longint'(span_hi) - longint'(span_lo);
    case ($urandom_range(0, 5))
      0: o = 0;
      1: o = d;
      2: o = d / 2;
      3: o = d / 2 + 1;
      default: o = longint'({$urandom, $urandom} % 64'(d + 1));
    endcase
    if (o > d) o = d;
    return SB'(longint'(span_lo) + o);
  endfunction

  function automatic logic [SB-1:0] pick_outside();
    if ($urandom_range(0, 1) == 0 && span_lo != S_MIN) return span_lo - 1;
    if (span_hi != S_MAX) return span_hi + 1;
    return $urandom;
  endfunction

  // Mostly a well-formed pass: restart the range, widen it, then map into it.
  // About one in ten is noise: random kinds, random first flags, wild samples.
  task automatic run_sequence();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        push_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      return;
    end
    base = pick_sample();
    push_item(REQ_GATHER, base, 1'b1);
    repeat ($urandom_range(0, 6)) push_item(REQ_GATHER, pick_sample(), 1'b0);
    repeat ($urandom_range(2, 12)) begin
      if ($urandom_range(0, 7) == 0)
        push_item(REQ_MAP, pick_outside(), 1'($urandom_range(0, 1)));
      else
        push_item(REQ_MAP, pick_in_range(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    bit quiet;
    bit pressed;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= CH_RED;
    span_lo      = '0;
    span_hi      = '0;
    base         = '0;
    sent         = 0;
    pressed      = 1'b0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset channel (red).
    push_item(REQ_MAP, 32'h0000_0000, 1'b0);     // reset range 0..0: zero span
    push_item(REQ_MAP, 32'h0000_0001, 1'b0);     // above range
    push_item(REQ_MAP, 32'hFFFF_FFFF, 1'b0);     // below range
    push_item(REQ_GATHER, 32'h0005_0000, 1'b0);  // no first yet: grows from 0..0
    push_item(REQ_GATHER, 32'hFFFF_0000, 1'b0);  // range -1.0 .. 5.0
    push_item(REQ_MAP, 32'hFFFF_0000, 1'b0);     // t = 0
    push_item(REQ_MAP, 32'h0005_0000, 1'b0);     // t = d, other channels saturate
    push_item(REQ_MAP, 32'h0002_0000, 1'b0);     // 2t == d
    push_item(REQ_MAP, 32'h0002_0001, 1'b1);     // just past half; first ignored on map
    push_item(REQ_GATHER, S_MIN, 1'b1);          // restart at the most negative value
    push_item(REQ_GATHER, S_MAX, 1'b0);          // widest range
    push_item(REQ_MAP, S_MIN, 1'b0);
    push_item(REQ_MAP, S_MAX, 1'b1);
    push_item(REQ_MAP, 32'h0000_0000, 1'b0);     // just above half of the widest span
    push_item(REQ_MAP, 32'hFFFF_FFFF, 1'b0);     // just below half
    push_item(REQ_GATHER, S_MAX, 1'b1);          // single-point range at the top
    push_item(REQ_MAP, S_MAX, 1'b0);
    push_item(REQ_MAP, S_MIN, 1'b0);             // below range
    push_item(REQ_GATHER, 32'h0000_0010, 1'b1);
    push_item(REQ_GATHER, 32'h0000_0013, 1'b0);  // d = 3
    push_item(REQ_MAP, 32'h0000_0011, 1'b0);
    push_item(REQ_MAP, 32'h0000_0012, 1'b0);

    // Random phases, one channel setting each; the spare code is one of them.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < NPH; p++) begin
      set_channel(PHASE_CH[2*p +: 2]);
      quiet = (p == NPH - 1);
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
        sink_idle_on = !quiet && ($urandom_range(0, 3) != 0);
        run_sequence();
        if (p == 1 && !pressed) begin
          // back-pressure: sink parked, source keeps offering maps
          pressed     = 1'b1;
          src_idle_on = 1'b0;
          hold_len    = HOLD;
          repeat (12) push_item(REQ_MAP, pick_in_range(), 1'b0);
        end
      end
    end

    settle();
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
